[hdl/tssd_pkg.sv]
// ----------------------------------------------------------------------------
// tssd_pkg
// shared types, codes and sizes for the threshold split / sort displacement block
// ----------------------------------------------------------------------------
package tssd_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DISP_W   = 8;
  localparam int EXT_W    = (CNT_W > DISP_W) ? CNT_W : DISP_W;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [DISP_W-1:0]        disp_t;

  typedef enum logic [1:0] {
    REG_LOW_EN   = 2'd0,
    REG_LOW      = 2'd1,
    REG_HIGH_EN  = 2'd2,
    REG_HIGH     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_LOW  = 2'd0,
    KIND_HIGH = 2'd1,
    KIND_DISP = 2'd2
  } kind_t;

  // control word broadcast to every cell of the row
  typedef struct packed {
    logic    ins;
    logic    shift;
    sample_t sample;
  } cell_ctl_t;

  function automatic disp_t sat_disp(input count_t cnt);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(cnt);
    return (ext > EXT_W'(255)) ? {DISP_W{1'b1}} : ext[DISP_W-1:0];
  endfunction

endpackage

[hdl/tssd_cell.sv]
// ----------------------------------------------------------------------------
// tssd_cell
// one sorting cell: holds one sorted entry and one arrival-order entry
// ----------------------------------------------------------------------------
module tssd_cell (
  input  logic                clk,
  input  tssd_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  logic                arr_we,
  input  logic                prev_gt,
  input  tssd_pkg::sample_t   prev_sorted,
  input  tssd_pkg::sample_t   next_sorted,
  input  tssd_pkg::sample_t   next_arrival,
  output tssd_pkg::sample_t   sorted,
  output tssd_pkg::sample_t   arrival,
  output logic                gt
);
  import tssd_pkg::*;

  sample_t sorted_r, sorted_nxt;
  sample_t arrival_r, arrival_nxt;

  // occupied and strictly above the incoming word: this entry moves up
  assign gt = occ && (sorted_r > ctl.sample);

  always_comb begin
    sorted_nxt  = sorted_r;
    arrival_nxt = arrival_r;
    if (ctl.shift) begin
      sorted_nxt  = next_sorted;
      arrival_nxt = next_arrival;
    end else if (ctl.ins) begin
      if (!occ || gt) begin
        sorted_nxt = prev_gt ? prev_sorted : ctl.sample;
      end
      if (arr_we) begin
        arrival_nxt = ctl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    sorted_r  <= sorted_nxt;
    arrival_r <= arrival_nxt;
  end

  assign sorted  = sorted_r;
  assign arrival = arrival_r;

endmodule

[hdl/tssd_chain.sv]
// ----------------------------------------------------------------------------
// tssd_chain
// row of sorting cells; inserts in place, shifts toward the head for readout
// ----------------------------------------------------------------------------
module tssd_chain (
  input  logic                clk,
  input  tssd_pkg::cell_ctl_t ctl,
  input  tssd_pkg::count_t    count,
  output tssd_pkg::sample_t   head_sorted,
  output tssd_pkg::sample_t   head_arrival
);
  import tssd_pkg::*;

  sample_t sorted_w  [CAPACITY];
  sample_t arrival_w [CAPACITY];
  logic    gt_w      [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic    prev_gt;
    sample_t prev_sorted;
    sample_t next_sorted;
    sample_t next_arrival;

    if (i == 0) begin : g_head
      assign prev_gt     = 1'b0;
      assign prev_sorted = '0;
    end else begin : g_body
      assign prev_gt     = gt_w[i-1];
      assign prev_sorted = sorted_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_sorted  = '0;
      assign next_arrival = '0;
    end else begin : g_inner
      assign next_sorted  = sorted_w[i+1];
      assign next_arrival = arrival_w[i+1];
    end

    tssd_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occ          (count_t'(i) < count),
      .arr_we       (count_t'(i) == count),
      .prev_gt      (prev_gt),
      .prev_sorted  (prev_sorted),
      .next_sorted  (next_sorted),
      .next_arrival (next_arrival),
      .sorted       (sorted_w[i]),
      .arrival      (arrival_w[i]),
      .gt           (gt_w[i])
    );
  end

  assign head_sorted  = sorted_w[0];
  assign head_arrival = arrival_w[0];

endmodule

[hdl/threshold_split_sort_displacement.sv]
// ----------------------------------------------------------------------------
// threshold_split_sort_displacement
// routes samples by low/high bound, keeps the rest in a sorting cell row and
// reports how many kept positions moved when sorted
// ----------------------------------------------------------------------------
// A word is taken on any clock edge with start high and busy low. Routed and
// kept words go at one per cycle while busy is low: a routed word appears on
// the out_ ports, flagged by out_strobe, in the cycle after it was taken. A
// kept word is inserted into the cell row at the edge that takes it, unless
// the row is full. After a word with in_final_item set, busy stays high while
// the row shifts its entries out past the head cell one per cycle for
// comparison; the displacement word is registered once the row is empty.
// out_strobe lasts one cycle and cannot be held off, so the receiver
// must take every word as it comes. Config writes are always accepted
// (cfg_ready is tied high) and belong in idle time only.
// ----------------------------------------------------------------------------
module threshold_split_sort_displacement (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tssd_pkg::sample_t   in_sample,
  input  logic                in_final_item,
  output logic                out_strobe,
  output logic [1:0]          out_kind,
  output tssd_pkg::sample_t   out_routed_value,
  output tssd_pkg::disp_t     out_displaced,
  output logic                out_overflowed,
  output logic                out_run_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import tssd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t  state_r, state_nxt;
  logic    low_en_r, high_en_r;
  sample_t low_r, high_r;
  count_t  count_r, count_nxt;
  count_t  disp_r, disp_nxt;
  logic    ovf_r, ovf_nxt;

  logic    out_strobe_r, out_strobe_nxt;
  kind_t   out_kind_r, out_kind_nxt;
  sample_t out_value_r, out_value_nxt;
  disp_t   out_disp_r, out_disp_nxt;
  logic    out_ovf_r, out_ovf_nxt;
  logic    out_end_r, out_end_nxt;

  logic      accept, low_hit, high_hit, keep, full;
  cell_ctl_t ctl;
  sample_t   head_sorted, head_arrival;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == ST_WALK);
  assign accept    = start && !busy;

  assign low_hit  = low_en_r && (in_sample <= low_r);
  assign high_hit = !low_hit && high_en_r && (in_sample >= high_r);
  assign keep     = !low_hit && !high_hit;
  assign full     = (count_r == count_t'(CAPACITY));

  assign ctl.ins    = accept && keep && !full;
  assign ctl.shift  = (state_r == ST_WALK) && (count_r != '0);
  assign ctl.sample = in_sample;

  tssd_chain u_chain (
    .clk          (clk),
    .ctl          (ctl),
    .count        (count_r),
    .head_sorted  (head_sorted),
    .head_arrival (head_arrival)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_en_r  <= 1'b0;
      low_r     <= '0;
      high_en_r <= 1'b0;
      high_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_LOW_EN:  low_en_r  <= cfg_data[0];
        REG_LOW:     low_r     <= sample_t'(cfg_data);
        REG_HIGH_EN: high_en_r <= cfg_data[0];
        REG_HIGH:    high_r    <= sample_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    disp_nxt       = disp_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    out_disp_nxt   = out_disp_r;
    out_ovf_nxt    = out_ovf_r;
    out_end_nxt    = out_end_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (keep) begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              count_nxt = count_r + count_t'(1);
            end
          end else begin
            out_strobe_nxt = 1'b1;
            out_kind_nxt   = low_hit ? KIND_LOW : KIND_HIGH;
            out_value_nxt  = in_sample;
            out_disp_nxt   = '0;
            out_ovf_nxt    = 1'b0;
            out_end_nxt    = !in_final_item;
          end
          if (in_final_item) begin
            disp_nxt  = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (count_r != '0) begin
          // head cell pair compared, row moves down by one
          if (head_sorted != head_arrival) begin
            disp_nxt = disp_r + count_t'(1);
          end
          count_nxt = count_r - count_t'(1);
        end else begin
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = KIND_DISP;
          out_value_nxt  = '0;
          out_disp_nxt   = sat_disp(disp_r);
          out_ovf_nxt    = ovf_r;
          out_end_nxt    = 1'b1;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    disp_r      <= disp_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_disp_r  <= out_disp_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_kind         = out_kind_r;
  assign out_routed_value = out_value_r;
  assign out_displaced    = out_disp_r;
  assign out_overflowed   = out_ovf_r;
  assign out_run_end      = out_end_r;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for threshold_split_sort_displacement. Samples go in
// over the start/busy handshake and every out_strobe word is compared field
// by field against a cycle-free predictor of the routing, the kept row and
// the displacement count. A short table of directed rows runs first, then
// phases of random sets under a range of bound settings and idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  import tssd_pkg::*;

  localparam int      RUN_LIMIT = 200000;
  localparam int      SETTLE    = 4;
  localparam sample_t S_MIN     = {1'b1, {63{1'b0}}};
  localparam sample_t S_MAX     = {1'b0, {63{1'b1}}};

  typedef struct packed {
    kind_t   kind;
    sample_t routed_value;
    disp_t   displaced;
    logic    overflowed;
    logic    run_end;
  } res_word_t;

  // one line of the directed table: a register write or a sample, with
  // up to two result words typed in where they are obvious
  typedef struct packed {
    logic        is_cfg;
    reg_index_t  idx;
    logic [63:0] data;
    sample_t     sample;
    logic        last;
    logic [1:0]  n_typed;
    res_word_t   t0;
    res_word_t   t1;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  sample_t     in_sample;
  logic        in_final_item;
  logic        out_strobe;
  logic [1:0]  out_kind;
  sample_t     out_routed_value;
  disp_t       out_displaced;
  logic        out_overflowed;
  logic        out_run_end;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_index_t  cfg_index;
  logic [63:0] cfg_data;

  threshold_split_sort_displacement dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .in_final_item    (in_final_item),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_routed_value (out_routed_value),
    .out_displaced    (out_displaced),
    .out_overflowed   (out_overflowed),
    .out_run_end      (out_run_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // predictor state
  logic      lo_en = 1'b0;
  sample_t   lo_bound = '0;
  logic      hi_en = 1'b0;
  sample_t   hi_bound = '0;
  sample_t   arrival [CAPACITY];
  sample_t   ranked [CAPACITY];
  int        kept_n = 0;
  logic      spilled = 1'b0;
  res_word_t step_words [2];

  res_word_t due_words [$];
  step_row_t dir_rows [$];
  int        fails = 0;
  int        idle_pct = 15;
  int        cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic res_word_t rw(kind_t k, sample_t v, int d, logic o, logic closes);
    res_word_t w;
    w.kind = k;
    w.routed_value = v;
    w.displaced = disp_t'(d);
    w.overflowed = o;
    w.run_end = closes;
    return w;
  endfunction

  function automatic step_row_t cfg_row(reg_index_t i, logic [63:0] d);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = i;
    r.data = d;
    return r;
  endfunction

  function automatic step_row_t item_row(sample_t s, logic l, int n = 0,
                                         res_word_t a = '0, res_word_t b = '0);
    step_row_t r;
    r = '0;
    r.sample = s;
    r.last = l;
    r.n_typed = 2'(n);
    r.t0 = a;
    r.t1 = b;
    return r;
  endfunction

  // routes one sample, updates the kept row and returns how many words it causes
  function automatic int route_sample(sample_t s, logic last);
    int n;
    int j;
    int moved;
    n = 0;
    if (lo_en && s <= lo_bound) begin
      step_words[n] = rw(KIND_LOW, s, 0, 1'b0, 1'b1);
      n++;
    end else if (hi_en && s >= hi_bound) begin
      step_words[n] = rw(KIND_HIGH, s, 0, 1'b0, 1'b1);
      n++;
    end else if (kept_n >= CAPACITY) begin
      spilled = 1'b1;
    end else begin
      arrival[kept_n] = s;
      j = kept_n;
      while (j > 0 && ranked[j-1] > s) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = s;
      kept_n++;
    end
    if (last) begin
      if (n > 0) step_words[n-1].run_end = 1'b0;
      moved = 0;
      for (int i = 0; i < kept_n; i++)
        if (ranked[i] != arrival[i]) moved++;
      step_words[n] = rw(KIND_DISP, '0, (moved > 255) ? 255 : moved, spilled, 1'b1);
      n++;
      kept_n = 0;
      spilled = 1'b0;
    end
    return n;
  endfunction

  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(9, 0))
      0, 1, 2: v = {$urandom, $urandom};
      3: begin
        case ($urandom_range(3, 0))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = '0;
          default: v = -64'sd1;
        endcase
      end
      4, 5: v = lo_bound + sample_t'($urandom_range(6, 0)) - 64'sd3;
      6: v = hi_bound + sample_t'($urandom_range(6, 0)) - 64'sd3;
      default: v = sample_t'($urandom_range(80, 0)) - 64'sd40;
    endcase
    return v;
  endfunction

  task automatic send_word(input sample_t s, input logic last, input int n_typed,
                           input res_word_t t0, input res_word_t t1);
    int gap;
    int n;
    gap = 0;
    while ($urandom_range(99, 0) < idle_pct) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_sample <= s;
    in_final_item <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = route_sample(s, last);
    if (n_typed == 0) begin
      for (int i = 0; i < n; i++) due_words.push_back(step_words[i]);
    end else begin
      due_words.push_back(t0);
      if (n_typed > 1) due_words.push_back(t1);
    end
  endtask

  // hold the sender until every word has come back and the row is settled
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t i, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (i)
      REG_LOW_EN:  lo_en = d[0];
      REG_LOW:     lo_bound = d;
      REG_HIGH_EN: hi_en = d[0];
      REG_HIGH:    hi_bound = d;
      default: ;
    endcase
  endtask

  // enables carry random upper bits, only bit 0 counts
  task automatic apply_bounds(input logic le, input sample_t lb,
                              input logic he, input sample_t hb);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[0] = le;
    cfg_write(REG_LOW_EN, r);
    cfg_write(REG_LOW, lb);
    r = {$urandom, $urandom};
    r[0] = he;
    cfg_write(REG_HIGH_EN, r);
    cfg_write(REG_HIGH, hb);
  endtask

  always @(posedge clk) begin : word_check
    res_word_t w;
    if (rst_n && out_strobe) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: kind %0d value %0d", out_kind, out_routed_value);
        fails++;
      end else begin
        w = due_words.pop_front();
        if (out_kind !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, out_kind);
          fails++;
        end
        if (out_routed_value !== w.routed_value) begin
          $error("routed_value: expected %0d, got %0d", w.routed_value, out_routed_value);
          fails++;
        end
        if (out_displaced !== w.displaced) begin
          $error("displaced: expected %0d, got %0d", w.displaced, out_displaced);
          fails++;
        end
        if (out_overflowed !== w.overflowed) begin
          $error("overflowed: expected %0d, got %0d", w.overflowed, out_overflowed);
          fails++;
        end
        if (out_run_end !== w.run_end) begin
          $error("run_end: expected %0d, got %0d", w.run_end, out_run_end);
          fails++;
        end
      end
    end
  end

  initial begin
    int      sent;
    int      len;
    logic    descending;
    sample_t s;

    rst_n = 1'b0;
    start = 1'b0;
    in_sample = '0;
    in_final_item = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LOW_EN;
    cfg_data = '0;

    // reset settings: both routes off, every sample kept
    dir_rows.push_back(item_row(64'sd0, 1'b1, 1, rw(KIND_DISP, '0, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(64'sd3, 1'b0));
    dir_rows.push_back(item_row(64'sd2, 1'b0));
    dir_rows.push_back(item_row(64'sd1, 1'b1, 1, rw(KIND_DISP, '0, 2, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(S_MAX, 1'b0));
    dir_rows.push_back(item_row(S_MIN, 1'b1, 1, rw(KIND_DISP, '0, 2, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(64'sd5, 1'b0));
    dir_rows.push_back(item_row(64'sd5, 1'b1, 1, rw(KIND_DISP, '0, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(-64'sd7, 1'b0));
    dir_rows.push_back(item_row(64'sd9, 1'b0));
    dir_rows.push_back(item_row(-64'sd8, 1'b1));
    dir_rows.push_back(cfg_row(REG_LOW_EN, 64'd1));
    dir_rows.push_back(cfg_row(REG_LOW, -64'sd100));
    dir_rows.push_back(cfg_row(REG_HIGH_EN, 64'd1));
    dir_rows.push_back(cfg_row(REG_HIGH, 64'sd100));
    // bounds are inclusive
    dir_rows.push_back(item_row(-64'sd100, 1'b0, 1, rw(KIND_LOW, -64'sd100, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(64'sd100, 1'b0, 1, rw(KIND_HIGH, 64'sd100, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(-64'sd99, 1'b0));
    dir_rows.push_back(item_row(64'sd99, 1'b0));
    dir_rows.push_back(item_row(S_MIN, 1'b1, 2, rw(KIND_LOW, S_MIN, 0, 1'b0, 1'b0),
                                rw(KIND_DISP, '0, 0, 1'b0, 1'b1)));
    // empty set closed by a routed sample
    dir_rows.push_back(item_row(S_MAX, 1'b1, 2, rw(KIND_HIGH, S_MAX, 0, 1'b0, 1'b0),
                                rw(KIND_DISP, '0, 0, 1'b0, 1'b1)));
    // overlapping bounds: low route wins
    dir_rows.push_back(cfg_row(REG_LOW, 64'sd10));
    dir_rows.push_back(cfg_row(REG_HIGH, -64'sd10));
    dir_rows.push_back(item_row(64'sd0, 1'b0, 1, rw(KIND_LOW, 64'sd0, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(64'sd11, 1'b0, 1, rw(KIND_HIGH, 64'sd11, 0, 1'b0, 1'b1)));
    dir_rows.push_back(item_row(64'sd11, 1'b1, 2, rw(KIND_HIGH, 64'sd11, 0, 1'b0, 1'b0),
                                rw(KIND_DISP, '0, 0, 1'b0, 1'b1)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].is_cfg) begin
        if (r == 0 || !dir_rows[r-1].is_cfg) wait_quiet();
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_word(dir_rows[r].sample, dir_rows[r].last, dir_rows[r].n_typed,
                  dir_rows[r].t0, dir_rows[r].t1);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      wait_quiet();
      idle_pct = (ph < 3) ? 15 : (ph < 6) ? 56 : 0;
      case (ph)
        0: apply_bounds(1'b0, {$urandom, $urandom}, 1'b0, {$urandom, $urandom});
        1: apply_bounds(1'b1, -64'sd1000, 1'b1, 64'sd1000);
        2: apply_bounds(1'b1, S_MIN, 1'b1, S_MAX);
        3: apply_bounds(1'b1, S_MAX, 1'b0, {$urandom, $urandom});
        4: apply_bounds(1'b0, {$urandom, $urandom}, 1'b1, S_MIN);
        5: apply_bounds(1'b1, 64'sd500, 1'b1, -64'sd500);
        6: apply_bounds(1'($urandom_range(1, 0)), {$urandom, $urandom},
                        1'($urandom_range(1, 0)), {$urandom, $urandom});
        7: apply_bounds(1'b0, {$urandom, $urandom}, 1'b0, {$urandom, $urandom});
        default: apply_bounds(1'b1, -64'sd50, 1'b1, 64'sd50);
      endcase
      sent = 0;
      while (sent < 60) begin
        descending = 1'b0;
        if (ph == 0 && sent == 0) begin
          // row filled exactly, every position moved
          len = CAPACITY;
          descending = 1'b1;
        end else if (ph == 7 && sent == 0) begin
          len = $urandom_range(CAPACITY + 12, CAPACITY + 1);
        end else if ($urandom_range(99, 0) < 3) begin
          len = $urandom_range(CAPACITY + 8, 100);
        end else begin
          len = $urandom_range(12, 1);
        end
        for (int k = 0; k < len; k++) begin
          s = descending ? sample_t'(len - k) : pick_sample();
          send_word(s, k == len - 1, 0, '0, '0);
          sent++;
        end
        if ($urandom_range(99, 0) < 5) wait_quiet();
      end
    end

    wait_quiet();
    repeat (CAPACITY + 8) @(posedge clk);
    if (fails == 0 && due_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
